FILE: src/direct_mapped_cache_lookup_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the direct-mapped cache lookup unit
// Clocked implication checks with reset disable.
// ----------------------------------------------------------------------------
`ifndef DIRECT_MAPPED_CACHE_LOOKUP_UNIT_ASSERT_SVH
`define DIRECT_MAPPED_CACHE_LOOKUP_UNIT_ASSERT_SVH

// same-cycle implication
`define DMCL_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dmcl: same-cycle check failed");

// next-cycle implication
`define DMCL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dmcl: next-cycle check failed");

`endif

FILE: src/dmcl_pkg.sv
// ----------------------------------------------------------------------------
// dmcl_pkg
// Geometry, field widths and result packing for the cache lookup unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dmcl_pkg;

  localparam int ADDR_W      = 32;
  localparam int LINE_COUNT  = 128;
  localparam int OFFSET_BITS = 5;
  localparam int INDEX_W     = $clog2(LINE_COUNT);
  localparam int BLOCK_W     = ADDR_W - OFFSET_BITS;
  localparam int TAG_W       = BLOCK_W - INDEX_W;
  localparam int CNT_W       = 32;

  // result beat layout, lowest field first
  localparam int OUT_OFFSET_LSB = 0;
  localparam int OUT_BLOCK_LSB  = OUT_OFFSET_LSB + OFFSET_BITS;
  localparam int OUT_INDEX_LSB  = OUT_BLOCK_LSB + BLOCK_W;
  localparam int OUT_TAG_LSB    = OUT_INDEX_LSB + INDEX_W;
  localparam int OUT_MISS_LSB   = OUT_TAG_LSB + TAG_W;
  localparam int OUT_REPL_LSB   = OUT_MISS_LSB + 1;
  localparam int OUT_EVICT_LSB  = OUT_REPL_LSB + 1;
  localparam int OUT_HIT_LSB    = OUT_EVICT_LSB + TAG_W;
  localparam int OUT_MCNT_LSB   = OUT_HIT_LSB + CNT_W;
  localparam int OUT_PAYLOAD_W  = OUT_MCNT_LSB + CNT_W;
  localparam int OUT_TDATA_W    = ((OUT_PAYLOAD_W + 7) / 8) * 8;

  typedef logic [TAG_W-1:0]   tag_t;
  typedef logic [INDEX_W-1:0] index_t;
  typedef logic [CNT_W-1:0]   cnt_t;

endpackage

`default_nettype wire

FILE: src/direct_mapped_cache_lookup_unit.sv
// ----------------------------------------------------------------------------
// direct_mapped_cache_lookup_unit
// Direct-mapped tag store: splits each address, checks hit or miss, installs
// the tag on a miss and reports the eviction and running hit/miss totals.
// ----------------------------------------------------------------------------
//  channel | dir | beat contents
//  in_     | in  | tdata: address[31:0]
//  out_    | out | tdata: byte_offset, block_number, line_index, tag_value,
//          |     |        is_miss, replaced_valid, evicted_tag, hit_total,
//          |     |        miss_total (lowest bit up, zero pad to 152 bits)
//
//  Each reference reads the tag RAM when it is accepted, then compares,
//  writes back the tag and loads the result register.
//  Reset clears the valid bits (flip-flops) and both counters at once; no
//  clearing pass is needed.
//  A new address is taken while an earlier result still waits at the output;
//  the compare stage holds when the result register is occupied.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module direct_mapped_cache_lookup_unit (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [dmcl_pkg::ADDR_W-1:0]      in_tdata,   // address
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // byte_offset, block_number, line_index, tag_value, is_miss,
  // replaced_valid, evicted_tag, hit_total, miss_total, zero pad
  output logic      [dmcl_pkg::OUT_TDATA_W-1:0] out_tdata
);

  import dmcl_pkg::*;

  typedef enum logic {S_IDLE, S_LOOK} state_t;

  state_t                 state_r;
  logic [ADDR_W-1:0]      addr_r;
  logic                   line_vld_r;
  logic [LINE_COUNT-1:0]  vld_r;
  cnt_t                   hit_cnt_r, hit_cnt_nxt;
  cnt_t                   miss_cnt_r, miss_cnt_nxt;
  logic                   out_tvalid_r;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  logic   in_fire;
  logic   look_fire;
  index_t in_idx;
  index_t cur_idx;
  tag_t   cur_tag;
  tag_t   rd_tag;
  logic   miss;
  logic   replaced;

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign look_fire  = (state_r == S_LOOK) && (!out_tvalid_r || out_tready);

  assign in_idx   = in_tdata[OFFSET_BITS +: INDEX_W];
  assign cur_idx  = addr_r[OFFSET_BITS +: INDEX_W];
  assign cur_tag  = addr_r[OFFSET_BITS + INDEX_W +: TAG_W];

  assign miss     = !line_vld_r || (rd_tag != cur_tag);
  assign replaced = line_vld_r && miss;

  dmcl_ram #(
    .WIDTH (TAG_W),
    .DEPTH (LINE_COUNT)
  ) u_tag_ram (
    .clk     (clk),
    .wr_en   (look_fire && miss),
    .wr_addr (cur_idx),
    .wr_data (cur_tag),
    .rd_en   (in_fire),
    .rd_addr (in_idx),
    .rd_data (rd_tag)
  );

  always_comb begin
    hit_cnt_nxt  = hit_cnt_r;
    miss_cnt_nxt = miss_cnt_r;
    if (look_fire) begin
      if (miss) begin
        miss_cnt_nxt = miss_cnt_r + cnt_t'(1);
      end else begin
        hit_cnt_nxt = hit_cnt_r + cnt_t'(1);
      end
    end
  end

  always_comb begin
    out_data_nxt = '0;
    out_data_nxt[OUT_OFFSET_LSB +: OFFSET_BITS] = addr_r[OFFSET_BITS-1:0];
    out_data_nxt[OUT_BLOCK_LSB +: BLOCK_W]      = addr_r[ADDR_W-1:OFFSET_BITS];
    out_data_nxt[OUT_INDEX_LSB +: INDEX_W]      = cur_idx;
    out_data_nxt[OUT_TAG_LSB +: TAG_W]          = cur_tag;
    out_data_nxt[OUT_MISS_LSB]                  = miss;
    out_data_nxt[OUT_REPL_LSB]                  = replaced;
    out_data_nxt[OUT_EVICT_LSB +: TAG_W]        = replaced ? rd_tag : '0;
    out_data_nxt[OUT_HIT_LSB +: CNT_W]          = hit_cnt_nxt;
    out_data_nxt[OUT_MCNT_LSB +: CNT_W]         = miss_cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      vld_r        <= '0;
      hit_cnt_r    <= '0;
      miss_cnt_r   <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      hit_cnt_r  <= hit_cnt_nxt;
      miss_cnt_r <= miss_cnt_nxt;
      if (look_fire) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            state_r <= S_LOOK;
          end
        end
        S_LOOK: begin
          if (look_fire) begin
            vld_r[cur_idx] <= 1'b1;
            state_r        <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // payload: address and sampled valid bit on accept, result on compare
  always_ff @(posedge clk) begin
    if (in_fire) begin
      addr_r     <= in_tdata;
      line_vld_r <= vld_r[in_idx];
    end
    if (look_fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

FILE: src/dmcl_ram.sv
// ----------------------------------------------------------------------------
// dmcl_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dmcl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    // hold read data while no read is issued
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: src/dmcl_checker.sv
// ----------------------------------------------------------------------------
// dmcl_checker
// Port-level checks on the result channel of the cache lookup unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "direct_mapped_cache_lookup_unit_assert.svh"

module dmcl_checker (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             out_tvalid,
  input wire logic                             out_tready,
  input wire logic [dmcl_pkg::OUT_TDATA_W-1:0] out_tdata
);

  import dmcl_pkg::*;

  logic out_stall;
  logic out_miss;
  logic out_repl;
  tag_t out_evict;
  logic index_ok;
  logic tag_ok;
  logic split_ok;

  assign out_stall = out_tvalid && !out_tready;
  assign out_miss  = out_tdata[OUT_MISS_LSB];
  assign out_repl  = out_tdata[OUT_REPL_LSB];
  assign out_evict = out_tdata[OUT_EVICT_LSB +: TAG_W];
  assign index_ok  = (out_tdata[OUT_INDEX_LSB +: INDEX_W] == out_tdata[OUT_BLOCK_LSB +: INDEX_W]);
  assign tag_ok    = (out_tdata[OUT_TAG_LSB +: TAG_W]
                      == out_tdata[OUT_BLOCK_LSB + INDEX_W +: TAG_W]);
  assign split_ok  = index_ok && tag_ok;

  // a stalled beat holds
  `DMCL_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, out_tvalid && $stable(out_tdata))

  // a replacement is always a miss
  `DMCL_ASSERT_IMPLY(a_repl_is_miss, clk, rst_n, out_tvalid && out_repl, out_miss)

  // no replacement, no evicted tag
  `DMCL_ASSERT_IMPLY(a_evict_zero, clk, rst_n, out_tvalid && !out_repl, out_evict == '0)

  // index and tag are the two halves of the block number
  `DMCL_ASSERT_IMPLY(a_split, clk, rst_n, out_tvalid, split_ok)

endmodule

bind direct_mapped_cache_lookup_unit dmcl_checker u_dmcl_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

FILE: bench/tb_direct_mapped_cache_lookup_unit.sv
// ----------------------------------------------------------------------------
// tb_direct_mapped_cache_lookup_unit
// Streams byte addresses into the cache lookup unit. A behavioural tag store
// predicts each lookup result, and every result beat is checked field by
// field. Both sides idle at random until the last third. The result side also
// stalls for one long stretch; the address side pauses once until the unit drains.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_direct_mapped_cache_lookup_unit;

  import dmcl_pkg::*;

  localparam int RANDOM_REFS = 1000;
  localparam int CYCLE_LIMIT = 300000;
  localparam int STALL_AT    = 150;
  localparam int STALL_LEN   = 80;
  localparam int DRAIN_AT    = 600;

  typedef struct {
    logic [OFFSET_BITS-1:0] byte_offset;
    logic [BLOCK_W-1:0]     block_number;
    index_t                 line_index;
    tag_t                   tag_value;
    logic                   is_miss;
    logic                   replaced_valid;
    tag_t                   evicted_tag;
    cnt_t                   hit_total;
    cnt_t                   miss_total;
  } lookup_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [ADDR_W-1:0]      in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;

  // shadow tag store
  logic   line_ok [LINE_COUNT];
  tag_t   line_tag_mem [LINE_COUNT];
  cnt_t   hits;
  cnt_t   misses;

  logic [ADDR_W-1:0] ref_addr_q[$];
  lookup_t           lookup_results_q[$];
  int                total_refs;
  int                refs_taken;
  int                refs_offered;
  int                mismatches;
  int                cycle_count;
  int                stall_left;
  bit                stall_done;
  bit                drain_done;
  bit                in_beat_done;

  direct_mapped_cache_lookup_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic lookup_t cache_lookup(input logic [ADDR_W-1:0] addr);
    lookup_t r;
    index_t  idx;
    tag_t    tg;
    idx = addr[OFFSET_BITS +: INDEX_W];
    tg  = addr[ADDR_W-1 -: TAG_W];
    r.byte_offset    = addr[OFFSET_BITS-1:0];
    r.block_number   = addr[ADDR_W-1:OFFSET_BITS];
    r.line_index     = idx;
    r.tag_value      = tg;
    r.is_miss        = 1'b0;
    r.replaced_valid = 1'b0;
    r.evicted_tag    = '0;
    if (line_ok[idx] && line_tag_mem[idx] == tg) begin
      hits = hits + 1'b1;
    end else begin
      r.is_miss = 1'b1;
      misses = misses + 1'b1;
      if (line_ok[idx]) begin
        r.replaced_valid = 1'b1;
        r.evicted_tag    = line_tag_mem[idx];
      end
      line_tag_mem[idx] = tg;
      line_ok[idx]      = 1'b1;
    end
    r.hit_total  = hits;
    r.miss_total = misses;
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("mismatch after %0d refs, %s: got %h want %h", refs_taken, what, got, want);
    mismatches++;
  endtask

  // idle percentages per phase: sender busy-ish first, then swapped, then none
  function automatic int sender_idle_pct();
    if (refs_taken < total_refs / 3) return 32;
    if (refs_taken < 2 * total_refs / 3) return 68;
    return 0;
  endfunction

  function automatic int receiver_idle_pct();
    if (refs_taken < total_refs / 3) return 68;
    if (refs_taken < 2 * total_refs / 3) return 32;
    return 0;
  endfunction

  // accept beats and check results at the rising edge
  always @(posedge clk) begin
    lookup_t want;
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("tb_direct_mapped_cache_lookup_unit NOT OK");
      $finish;
    end else begin
      in_beat_done = rst_n && in_tvalid && in_tready;
      if (in_beat_done) begin
        lookup_results_q.push_back(cache_lookup(in_tdata));
        refs_taken++;
      end
      if (rst_n && out_tvalid && out_tready) begin
        if (lookup_results_q.size() == 0) begin
          flag_mismatch("result beat with nothing expected", out_tdata[31:0], '0);
        end else begin
          want = lookup_results_q.pop_front();
          if (out_tdata[OUT_OFFSET_LSB +: OFFSET_BITS] !== want.byte_offset)
            flag_mismatch("byte_offset", out_tdata[OUT_OFFSET_LSB +: OFFSET_BITS],
                          want.byte_offset);
          if (out_tdata[OUT_BLOCK_LSB +: BLOCK_W] !== want.block_number)
            flag_mismatch("block_number", out_tdata[OUT_BLOCK_LSB +: BLOCK_W],
                          want.block_number);
          if (out_tdata[OUT_INDEX_LSB +: INDEX_W] !== want.line_index)
            flag_mismatch("line_index", out_tdata[OUT_INDEX_LSB +: INDEX_W],
                          want.line_index);
          if (out_tdata[OUT_TAG_LSB +: TAG_W] !== want.tag_value)
            flag_mismatch("tag_value", out_tdata[OUT_TAG_LSB +: TAG_W], want.tag_value);
          if (out_tdata[OUT_MISS_LSB] !== want.is_miss)
            flag_mismatch("is_miss", out_tdata[OUT_MISS_LSB], want.is_miss);
          if (out_tdata[OUT_REPL_LSB] !== want.replaced_valid)
            flag_mismatch("replaced_valid", out_tdata[OUT_REPL_LSB], want.replaced_valid);
          if (out_tdata[OUT_EVICT_LSB +: TAG_W] !== want.evicted_tag)
            flag_mismatch("evicted_tag", out_tdata[OUT_EVICT_LSB +: TAG_W],
                          want.evicted_tag);
          if (out_tdata[OUT_HIT_LSB +: CNT_W] !== want.hit_total)
            flag_mismatch("hit_total", out_tdata[OUT_HIT_LSB +: CNT_W], want.hit_total);
          if (out_tdata[OUT_MCNT_LSB +: CNT_W] !== want.miss_total)
            flag_mismatch("miss_total", out_tdata[OUT_MCNT_LSB +: CNT_W], want.miss_total);
        end
      end
    end
  end

  // address driver: hold an unaccepted beat, otherwise offer the next one
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && !in_beat_done) begin
      in_tvalid <= 1'b1;
    end else if (refs_offered == DRAIN_AT && !drain_done) begin
      // pause until every lookup has come back
      in_tvalid <= 1'b0;
      if (lookup_results_q.size() == 0 && !out_tvalid) drain_done = 1'b1;
    end else if (ref_addr_q.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct()) begin
      in_tvalid <= 1'b1;
      in_tdata  <= ref_addr_q.pop_front();
      refs_offered++;
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // result receiver, with one long hold-off to back the unit up
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else if (!stall_done && refs_taken >= STALL_AT) begin
      stall_done = 1'b1;
      stall_left = STALL_LEN;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= receiver_idle_pct());
    end
  end

  initial begin
    tag_t              tag_pool [4];
    logic [ADDR_W-1:0] addr;
    index_t            idx;
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    out_tready   = 1'b0;
    hits         = '0;
    misses       = '0;
    refs_taken   = 0;
    refs_offered = 0;
    mismatches   = 0;
    cycle_count  = 0;
    stall_left   = 0;
    stall_done   = 1'b0;
    drain_done   = 1'b0;
    in_beat_done = 1'b0;
    for (int i = 0; i < LINE_COUNT; i++) begin
      line_ok[i]      = 1'b0;
      line_tag_mem[i] = '0;
    end

    // miss on an empty line, then a hit on the same line at the top offset
    ref_addr_q.push_back(32'h0000_0000);
    ref_addr_q.push_back(32'h0000_001F);
    // same line, other tag: replace, then replace back
    ref_addr_q.push_back(32'h0000_1000);
    ref_addr_q.push_back(32'h0000_0000);
    // all-ones address: highest line and tag
    ref_addr_q.push_back(32'hFFFF_FFFF);
    ref_addr_q.push_back(32'hFFFF_FFE0);
    ref_addr_q.push_back(32'h0000_0FE0);
    ref_addr_q.push_back(32'h0000_0FFF);
    ref_addr_q.push_back(32'hFFFF_F000);
    ref_addr_q.push_back(32'h0000_0010);
    ref_addr_q.push_back(32'hAAAA_AAAA);
    ref_addr_q.push_back(32'h5555_5555);
    ref_addr_q.push_back(32'hAAAA_AAA0);
    ref_addr_q.push_back(32'h8000_0000);
    ref_addr_q.push_back(32'h0000_0020);
    ref_addr_q.push_back(32'h7FFF_FFFF);
    ref_addr_q.push_back(32'h0000_0000);

    // mostly a few tags over a narrow set of lines, so hits and evictions recur
    tag_pool[0] = '0;
    tag_pool[1] = '1;
    tag_pool[2] = tag_t'($urandom);
    tag_pool[3] = tag_t'($urandom);
    for (int i = 0; i < RANDOM_REFS; i++) begin
      if ($urandom_range(0, 9) < 2) begin
        addr = $urandom;
      end else begin
        if ($urandom_range(0, 3) == 0) idx = index_t'($urandom_range(0, LINE_COUNT - 1));
        else idx = index_t'($urandom_range(0, 15));
        addr = {tag_pool[$urandom_range(0, 3)], idx, OFFSET_BITS'($urandom)};
      end
      ref_addr_q.push_back(addr);
    end
    total_refs = ref_addr_q.size();

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    wait (refs_taken == total_refs);
    wait (lookup_results_q.size() == 0);
    repeat (10) @(posedge clk);
    if (lookup_results_q.size() != 0)
      flag_mismatch("results never delivered", lookup_results_q.size(), '0);

    if (mismatches == 0) begin
      $display("tb_direct_mapped_cache_lookup_unit OK");
    end else begin
      $display("tb_direct_mapped_cache_lookup_unit NOT OK");
    end
    $finish;
  end

endmodule

FILE: direct_mapped_cache_lookup_unit.f
+incdir+src
src/dmcl_pkg.sv
src/dmcl_ram.sv
src/direct_mapped_cache_lookup_unit.sv
src/dmcl_checker.sv
bench/tb_direct_mapped_cache_lookup_unit.sv
